// File: rtl/slxfp_pkg.sv
`timescale 1ns / 1ps

package slxfp_pkg;

  // bytes counted into the frame before the payload: length byte plus command bytes
  localparam int HEADER_BYTES = 3;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = CFG_INDEX_W'(1);

  localparam logic [7:0] START_BYTE_RESET = 8'd254;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd191;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] position;
  } res_t;

endpackage

// File: rtl/sof_length_xor_frame_parser_unit.sv
`timescale 1ns / 1ps

// channel | ports                                    | transfer when
// --------+------------------------------------------+------------------------
// in      | in_valid, in_stall, in_rx_byte           | in_valid && !in_stall
// out     | out_valid, out_stall, out_kind/value/pos | out_valid && !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
// one byte per cycle unless in_stall; a result goes to out_* as its byte transfers,
// or to the skid entry while out_* is held. the rate is set by the frame state update,
// one step per byte, plus an output register backed by a single skid entry.
// in_stall rises only once the output register and the skid entry both hold results.
// rst_n is synchronous: parser returns to hunting, registers take their reset values.
// cfg_ready is always high; writes to unknown indexes are dropped.

module sof_length_xor_frame_parser_unit #(
  parameter int HeaderBytes = slxfp_pkg::HEADER_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_value,
  output logic [7:0]                       out_position,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slxfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);

  logic            in_accept;
  logic            res_valid;
  slxfp_pkg::res_t res;
  logic            new_res;
  logic            out_free;

  logic [7:0]      start_byte_r;
  logic [7:0]      max_length_r;
  logic            out_valid_r;
  slxfp_pkg::res_t out_r;
  logic            skid_valid_r;
  slxfp_pkg::res_t skid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign new_res   = in_accept && res_valid;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= slxfp_pkg::START_BYTE_RESET;
      max_length_r <= slxfp_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == slxfp_pkg::CFG_START_BYTE) start_byte_r <= cfg_data;
      if (cfg_index == slxfp_pkg::CFG_MAX_LENGTH) max_length_r <= cfg_data;
    end
  end

  slxfp_core #(
    .HeaderBytes (HeaderBytes)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .in_byte    (in_rx_byte),
    .start_byte (start_byte_r),
    .max_length (max_length_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || new_res;
      skid_valid_r <= 1'b0;
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && new_res) begin
      skid_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_value    = out_r.value;
  assign out_position = out_r.position;

endmodule

// File: rtl/slxfp_core.sv
`timescale 1ns / 1ps

module slxfp_core #(
  parameter int HeaderBytes = slxfp_pkg::HEADER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        start_byte,
  input  logic [7:0]        max_length,
  output logic              res_valid,
  output slxfp_pkg::res_t   res
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_FCS
  } stage_t;

  stage_t     stage_r, stage_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;

  logic [8:0] total_sum;
  logic [7:0] total_sat;
  logic [7:0] idx_base;
  logic [7:0] xor_base;
  logic [7:0] len_base;
  logic [7:0] idx_inc;

  assign total_sum = {1'b0, in_byte} + 9'(HeaderBytes);
  assign total_sat = total_sum[8] ? 8'hFF : total_sum[7:0];

  // the length byte restarts the frame counters
  assign idx_base = (stage_r == ST_LEN) ? 8'd0 : byte_index_r;
  assign xor_base = (stage_r == ST_LEN) ? 8'd0 : running_xor_r;
  assign len_base = (stage_r == ST_LEN) ? total_sat : frame_length_r;
  assign idx_inc  = idx_base + 8'd1;

  always_comb begin
    stage_nxt        = stage_r;
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    running_xor_nxt  = running_xor_r;
    res_valid        = 1'b0;
    res.kind         = slxfp_pkg::KIND_BYTE;
    res.value        = in_byte;
    res.position     = idx_base;
    case (stage_r)
      ST_HUNT: begin
        if (in_byte == start_byte) stage_nxt = ST_LEN;
      end
      ST_LEN, ST_DATA: begin
        if ((stage_r == ST_LEN) && (in_byte > max_length)) begin
          stage_nxt = ST_HUNT;
        end else begin
          res_valid        = 1'b1;
          frame_length_nxt = len_base;
          running_xor_nxt  = xor_base ^ in_byte;
          byte_index_nxt   = idx_inc;
          if ((idx_inc == len_base) || (idx_inc == 8'd0)) stage_nxt = ST_FCS;
          else stage_nxt = ST_DATA;
        end
      end
      ST_FCS: begin
        stage_nxt    = ST_HUNT;
        res_valid    = 1'b1;
        res.kind     = (in_byte == running_xor_r) ? slxfp_pkg::KIND_GOOD
                                                   : slxfp_pkg::KIND_BAD;
        res.position = 8'd0;
      end
      default: begin
        stage_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r        <= ST_HUNT;
      byte_index_r   <= 8'd0;
      frame_length_r <= 8'd0;
      running_xor_r  <= 8'd0;
    end else if (accept) begin
      stage_r        <= stage_nxt;
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
      running_xor_r  <= running_xor_nxt;
    end
  end

endmodule

// File: rtl/slxfp_checker.sv
`timescale 1ns / 1ps

module slxfp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       out_kind,
  input logic [7:0]                       out_value,
  input logic [7:0]                       out_position,
  input logic                             cfg_ready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_position))
    else $error("out payload changed while stalled");

  // backpressure only once a result is already waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == slxfp_pkg::KIND_BYTE) || (out_kind == slxfp_pkg::KIND_GOOD)
      || (out_kind == slxfp_pkg::KIND_BAD))
    else $error("illegal out_kind");

  // check results carry position zero
  a_check_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != slxfp_pkg::KIND_BYTE) |-> out_position == 8'd0)
    else $error("check result with nonzero position");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg_ready dropped");

endmodule

bind sof_length_xor_frame_parser_unit slxfp_checker u_slxfp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_kind     (out_kind),
  .out_value    (out_value),
  .out_position (out_position),
  .cfg_ready    (cfg_ready)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef enum logic [1:0] {HUNTING, LENGTH_NEXT, FRAME_BYTES, CHECK_NEXT} parse_stage_t;

  // cycles with no transfer on any channel before the run is declared hung
  localparam int IDLE_LIMIT = 2000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [7:0]                        in_rx_byte = 8'h00;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [1:0]                        out_kind;
  logic [7:0]                        out_value;
  logic [7:0]                        out_position;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [slxfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]                        cfg_data = 8'h00;

  sof_length_xor_frame_parser_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_position (out_position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser prediction state and register copies
  parse_stage_t stage_q = HUNTING;
  logic [7:0]   byte_pos = 8'd0;
  logic [7:0]   frame_total = 8'd0;
  logic [7:0]   xor_acc = 8'd0;
  logic [7:0]   start_reg = slxfp_pkg::START_BYTE_RESET;
  logic [7:0]   max_len_reg = slxfp_pkg::MAX_LENGTH_RESET;

  slxfp_pkg::res_t results_due[$];
  logic [7:0]      rx_bytes_to_send[$];

  // generator's view of the current settings
  logic [7:0]   gen_start = slxfp_pkg::START_BYTE_RESET;
  logic [7:0]   gen_max = slxfp_pkg::MAX_LENGTH_RESET;

  bit           in_taken = 1'b0;
  int           idle_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  bytes_in = 0;
  int unsigned  frame_bytes_seen = 0;
  int unsigned  good_checks = 0;
  int unsigned  bad_checks = 0;
  int unsigned  settings_used = 1;

  task automatic take_frame_byte(input logic [7:0] b);
    slxfp_pkg::res_t r;
    xor_acc    = xor_acc ^ b;
    r.kind     = slxfp_pkg::KIND_BYTE;
    r.value    = b;
    r.position = byte_pos;
    results_due.push_back(r);
    byte_pos = byte_pos + 8'd1;
    if (byte_pos == frame_total || byte_pos == 8'd0) stage_q = CHECK_NEXT;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    slxfp_pkg::res_t r;
    logic [8:0]      total;
    case (stage_q)
      HUNTING: begin
        if (b == start_reg) stage_q = LENGTH_NEXT;
      end
      LENGTH_NEXT: begin
        if (b > max_len_reg) begin
          // oversize length drops the frame without being taken as a start byte
          stage_q = HUNTING;
        end else begin
          total = {1'b0, b} + 9'(slxfp_pkg::HEADER_BYTES);
          if (total > 9'd255) total = 9'd255;
          frame_total = total[7:0];
          byte_pos    = 8'd0;
          xor_acc     = 8'd0;
          stage_q     = FRAME_BYTES;
          take_frame_byte(b);
        end
      end
      FRAME_BYTES: take_frame_byte(b);
      default: begin
        stage_q    = HUNTING;
        r.kind     = (b == xor_acc) ? slxfp_pkg::KIND_GOOD : slxfp_pkg::KIND_BAD;
        r.value    = b;
        r.position = 8'd0;
        results_due.push_back(r);
      end
    endcase
  endtask

  // monitor: checks result transfers, feeds accepted bytes and writes to the predictor
  always @(posedge clk) begin : monitor
    slxfp_pkg::res_t want;
    bit              busy;
    if (rst_n) begin
      busy = 1'b0;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d value %0h position %0d",
                   $time, out_kind, out_value, out_position);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, out_kind);
            mismatches++;
          end
          if (out_value !== want.value) begin
            $display("%0t: value mismatch, expected %0h, got %0h", $time, want.value, out_value);
            mismatches++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_position);
            mismatches++;
          end
          case (want.kind)
            slxfp_pkg::KIND_BYTE: frame_bytes_seen++;
            slxfp_pkg::KIND_GOOD: good_checks++;
            default:              bad_checks++;
          endcase
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        busy = 1'b1;
        bytes_in++;
        parse_rx_byte(in_rx_byte);
      end
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        case (cfg_index)
          slxfp_pkg::CFG_START_BYTE: start_reg = cfg_data;
          slxfp_pkg::CFG_MAX_LENGTH: max_len_reg = cfg_data;
          default: ;
        endcase
      end
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
          $display("tb failed");
          $finish;
        end
      end
    end
  end

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rx_bytes_to_send.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_bytes_to_send.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: switches between free, light, periodic and heavy stalling
  int stall_tick = 0;
  int stall_mode = 0;

  always @(negedge clk) begin : receiver
    stall_tick++;
    if (stall_tick % 150 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ((stall_tick % 5) < 2);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic write_reg(input logic [slxfp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every byte is sent and every result is in, then let the pipeline settle
  task automatic drain();
    while (rx_bytes_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) rx_bytes_to_send.push_back(8'($urandom_range(0, 255)));
  endtask

  // one frame with the current start byte; forced_len < 0 picks a mostly small length
  task automatic add_frame(input int forced_len);
    int         sel;
    int         len;
    int         cap;
    int         body;
    logic [7:0] acc;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    rx_bytes_to_send.push_back(gen_start);
    if (forced_len < 0 && sel < 8 && gen_max < 8'd255) begin
      // length above the limit, frame dropped
      rx_bytes_to_send.push_back(8'($urandom_range(int'(gen_max) + 1, 255)));
      return;
    end
    if (forced_len >= 0) begin
      len = forced_len;
    end else begin
      cap = (sel < 85) ? 8 : 40;
      if (int'(gen_max) < cap) cap = int'(gen_max);
      len = $urandom_range(0, cap);
    end
    body = len + slxfp_pkg::HEADER_BYTES;
    if (body > 255) body = 255;
    acc = 8'(len);
    rx_bytes_to_send.push_back(8'(len));
    for (int k = 1; k < body; k++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0) b = gen_start;
      acc = acc ^ b;
      rx_bytes_to_send.push_back(b);
    end
    if (forced_len < 0 && $urandom_range(0, 24) == 0) return;
    if ($urandom_range(0, 3) == 0)
      rx_bytes_to_send.push_back(acc ^ 8'($urandom_range(1, 255)));
    else
      rx_bytes_to_send.push_back(acc);
  endtask

  task automatic set_regs(input logic [7:0] sb, input logic [7:0] ml);
    drain();
    write_reg(slxfp_pkg::CFG_START_BYTE, sb);
    write_reg(slxfp_pkg::CFG_MAX_LENGTH, ml);
    // unknown index must leave both registers alone
    write_reg(slxfp_pkg::CFG_INDEX_W'($urandom_range(2, 15)), 8'($urandom_range(0, 255)));
    gen_start = sb;
    gen_max   = ml;
    settings_used++;
  endtask

  task automatic run_phase(input logic [7:0] sb, input logic [7:0] ml, input int n_frames);
    set_regs(sb, ml);
    repeat (n_frames) begin
      add_noise();
      add_frame(-1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: noise, minimal frame with good check
    rx_bytes_to_send.push_back(8'h00); rx_bytes_to_send.push_back(8'hFF);
    rx_bytes_to_send.push_back(8'd254); rx_bytes_to_send.push_back(8'd0);
    rx_bytes_to_send.push_back(8'hFF); rx_bytes_to_send.push_back(8'h00);
    rx_bytes_to_send.push_back(8'hFF);
    // oversize length, then oversize length equal to the start byte
    rx_bytes_to_send.push_back(8'd254); rx_bytes_to_send.push_back(8'd192);
    rx_bytes_to_send.push_back(8'd254); rx_bytes_to_send.push_back(8'd254);
    rx_bytes_to_send.push_back(8'd7);
    // start byte inside the frame, bad check
    rx_bytes_to_send.push_back(8'd254); rx_bytes_to_send.push_back(8'd1);
    rx_bytes_to_send.push_back(8'd254); rx_bytes_to_send.push_back(8'h12);
    rx_bytes_to_send.push_back(8'h34); rx_bytes_to_send.push_back(8'h00);
    drain();
    // all-ones index and data are not a register
    write_reg(slxfp_pkg::CFG_INDEX_W'(15), 8'hFF);
    rx_bytes_to_send.push_back(8'd254); rx_bytes_to_send.push_back(8'd0);
    rx_bytes_to_send.push_back(8'hA5); rx_bytes_to_send.push_back(8'h5A);
    rx_bytes_to_send.push_back(8'hFF);

    // largest lengths, including the saturated frame size
    set_regs(8'hA5, 8'd255);
    add_frame(255);
    set_regs(8'h00, 8'd252);
    add_frame(252);
    set_regs(8'hFE, 8'd191);
    add_frame(191);

    run_phase(8'h00, 8'd0, 6);
    run_phase(8'hFF, 8'd252, 6);
    run_phase(8'h55, 8'd5, 6);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 20)), 6);
    run_phase(slxfp_pkg::START_BYTE_RESET, slxfp_pkg::MAX_LENGTH_RESET, 6);
    run_phase(8'hAA, 8'd2, 6);
    run_phase(8'($urandom_range(0, 255)), 8'd252, 6);
    run_phase(8'h7E, 8'd40, 6);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 252)), 6);

    drain();
    repeat (10) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results expected, got none", $time, results_due.size());
      mismatches += results_due.size();
    end
    $display("bytes sent %0d over %0d register settings, frame bytes out %0d",
             bytes_in, settings_used, frame_bytes_seen);
    $display("frame ends: %0d good check, %0d bad check, mismatches %0d",
             good_checks, bad_checks, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/slxfp_pkg.sv
rtl/slxfp_core.sv
rtl/sof_length_xor_frame_parser_unit.sv
rtl/slxfp_checker.sv
verif/tb.sv
